// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fba_pkg.sv =====
// shared types and constants for the best fit segment allocator
// no dependencies; imported by every allocator module
package fba_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ADDR_BITS_DEF    = 16;
   localparam int GRAN_W           = 17;
   localparam int ROUND_STEPS      = 17;
   localparam int SIZE_W           = 18;

   localparam logic [7:0]        FREE_OWNER = 8'hFF;
   localparam logic [GRAN_W-1:0] GRAN_MAX   = 17'h10000;
   localparam logic [GRAN_W-1:0] GRAN_RESET = 17'd16;

   // operation codes
   localparam logic [1:0] FUNC_ALLOC     = 2'd0;
   localparam logic [1:0] FUNC_FREE      = 2'd1;
   localparam logic [1:0] FUNC_TRANSLATE = 2'd2;
   localparam logic [1:0] FUNC_SIZE      = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ALLOC_UNIT  = 2'd0;
   localparam logic [1:0] CSR_PAGE_SIZE   = 2'd1;
   localparam logic [1:0] CSR_MEMORY_SIZE = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_WRITE,
      OP_INSERT,
      OP_MERGE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        scan_alloc;
   } cell_ctl_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_ROUND,
      S_SCAN,
      S_DECIDE,
      S_INSERT,
      S_WRITE,
      S_FILL2,
      S_MERGE_HI,
      S_MERGE_LO
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [6:0]  owner_id;
      logic [16:0] request_bytes;
      logic [15:0] offset;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [16:0]       value;
      logic              fill_valid;
      logic [15:0]       fill_start;
      logic [16:0]       fill_length;
      logic signed [7:0] fill_value;
      logic              last;
   } rsp_type;

endpackage

// ===== hw/rtl/fba_rounder.sv =====
// rounds a request up to the page and to the allocation unit
// depends on fba_pkg; two restoring remainder units run side by side
module fba_rounder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fba_pkg::GRAN_W-1:0] request_bytes,
   input  logic [fba_pkg::GRAN_W-1:0] unit,
   input  logic [fba_pkg::GRAN_W-1:0] page,
   output logic                       done,
   output logic [fba_pkg::SIZE_W-1:0] size,
   output logic [fba_pkg::SIZE_W-1:0] used
);
   import fba_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [GRAN_W-1:0]   dvd_ff, dvd_in;
   logic [GRAN_W-1:0]   q_ff, q_in;
   logic [GRAN_W-1:0]   rp_ff, rp_in;
   logic [GRAN_W-1:0]   ru_ff, ru_in;
   logic [SIZE_W-1:0]   tp, tu;
   logic [GRAN_W-1:0]   dminus;
   logic [SIZE_W-1:0]   size_raw, used_raw;

   // request minus one, a zero request counts as one
   assign dminus = (request_bytes == '0) ? '0 : request_bytes - GRAN_W'(1);

   // one quotient bit per cycle for both granules
   always_comb begin
      tp      = {rp_ff, q_ff[GRAN_W-1]};
      tu      = {ru_ff, q_ff[GRAN_W-1]};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rp_in   = rp_ff;
      ru_in   = ru_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dminus;
         q_in   = dminus;
         rp_in  = '0;
         ru_in  = '0;
      end else if (run_ff) begin
         q_in  = {q_ff[GRAN_W-2:0], 1'b0};
         rp_in = (tp >= SIZE_W'(page)) ? GRAN_W'(tp - SIZE_W'(page)) : GRAN_W'(tp);
         ru_in = (tu >= SIZE_W'(unit)) ? GRAN_W'(tu - SIZE_W'(unit)) : GRAN_W'(tu);
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROUND_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rp_ff  <= rp_in;
      ru_ff  <= ru_in;
   end

   // rounded value is (request - 1) - remainder + granule
   always_comb begin
      size_raw = SIZE_W'(dvd_ff) - SIZE_W'(rp_ff) + SIZE_W'(page);
      used_raw = SIZE_W'(dvd_ff) - SIZE_W'(ru_ff) + SIZE_W'(unit);
   end

   assign done = done_ff;
   assign size = size_raw;
   assign used = (used_raw > size_raw) ? size_raw : used_raw;

endmodule

// ===== hw/rtl/fba_cell.sv =====
// one entry of the segment table with its slice of the search wave
// depends on fba_pkg; cells are chained by the allocator top level
module fba_cell #(
   parameter int ADDR_BITS    = fba_pkg::ADDR_BITS_DEF,
   parameter int MAX_SEGMENTS = fba_pkg::MAX_SEGMENTS_DEF,
   parameter int IDX          = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fba_pkg::cell_ctl_type                 ctl,
   input  logic [$clog2(MAX_SEGMENTS)-1:0]       pos,
   input  logic [$clog2(MAX_SEGMENTS+1)-1:0]     count,
   input  logic [7:0]                            key_owner,
   input  logic [((ADDR_BITS+1>18)?ADDR_BITS+1:18)-1:0] size,
   input  logic [7:0]                            wr_owner,
   input  logic [ADDR_BITS-1:0]                  wr_start,
   input  logic [ADDR_BITS:0]                    wr_length,
   input  logic [ADDR_BITS:0]                    wr_used,
   input  logic [7:0]                            prev_owner,
   input  logic [ADDR_BITS-1:0]                  prev_start,
   input  logic [ADDR_BITS:0]                    prev_length,
   input  logic [ADDR_BITS:0]                    prev_used,
   input  logic [7:0]                            next_owner,
   input  logic [ADDR_BITS-1:0]                  next_start,
   input  logic [ADDR_BITS:0]                    next_length,
   input  logic [ADDR_BITS:0]                    next_used,
   output logic [7:0]                            owner,
   output logic [ADDR_BITS-1:0]                  start,
   output logic [ADDR_BITS:0]                    length,
   output logic [ADDR_BITS:0]                    used,
   input  logic                                  cin_found,
   input  logic [$clog2(MAX_SEGMENTS)-1:0]       cin_idx,
   input  logic [ADDR_BITS-1:0]                  cin_start,
   input  logic [ADDR_BITS:0]                    cin_length,
   output logic                                  cout_found,
   output logic [$clog2(MAX_SEGMENTS)-1:0]       cout_idx,
   output logic [ADDR_BITS-1:0]                  cout_start,
   output logic [ADDR_BITS:0]                    cout_length
);
   import fba_pkg::*;

   localparam int IW    = $clog2(MAX_SEGMENTS);
   localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
   localparam int LEN_W = ADDR_BITS + 1;
   localparam int CW    = (LEN_W > 18) ? LEN_W : 18;

   logic [7:0]           owner_ff, owner_in;
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic [LEN_W-1:0]     used_ff, used_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [ADDR_BITS-1:0] cstart_ff, cstart_in;
   logic [LEN_W-1:0]     clength_ff, clength_in;
   logic                 live, here, above, take;

   assign live  = CNTW'(IDX) < count;
   assign here  = pos == IW'(IDX);
   assign above = IW'(IDX) > pos;

   // search wave: best fitting free entry or first entry of the owner
   always_comb begin
      if (ctl.scan_alloc) begin
         take = live && (owner_ff == FREE_OWNER) && (CW'(length_ff) >= size) &&
                (!cin_found || (length_ff < cin_length));
      end else begin
         take = live && (owner_ff == key_owner) && !cin_found;
      end
      found_in   = take ? 1'b1        : cin_found;
      idx_in     = take ? IW'(IDX)    : cin_idx;
      cstart_in  = take ? start_ff    : cin_start;
      clength_in = take ? length_ff   : cin_length;
   end

   // entry update: write, shift up for an insert, shift down for a merge
   always_comb begin
      owner_in  = owner_ff;
      start_in  = start_ff;
      length_in = length_ff;
      used_in   = used_ff;
      case (ctl.op)
         OP_WRITE: begin
            if (here) begin
               owner_in  = wr_owner;
               start_in  = wr_start;
               length_in = wr_length;
               used_in   = wr_used;
            end
         end
         OP_INSERT: begin
            if (here) begin
               owner_in  = wr_owner;
               start_in  = wr_start;
               length_in = wr_length;
               used_in   = wr_used;
            end else if (above) begin
               owner_in  = prev_owner;
               start_in  = prev_start;
               length_in = prev_length;
               used_in   = prev_used;
            end
         end
         OP_MERGE: begin
            if (here) begin
               length_in = length_ff + next_length;
            end else if (above) begin
               owner_in  = next_owner;
               start_in  = next_start;
               length_in = next_length;
               used_in   = next_used;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff     <= idx_in;
      cstart_ff  <= cstart_in;
      clength_ff <= clength_in;
      owner_ff   <= owner_in;
      start_ff   <= start_in;
      length_ff  <= length_in;
      used_ff    <= used_in;
   end

   assign owner       = owner_ff;
   assign start       = start_ff;
   assign length      = length_ff;
   assign used        = used_ff;
   assign cout_found  = found_ff;
   assign cout_idx    = idx_ff;
   assign cout_start  = cstart_ff;
   assign cout_length = clength_ff;

endmodule

// ===== hw/rtl/best_fit_segment_allocator.sv =====
// Best fit segment allocator. A transaction is taken when start is high and busy is low; busy
// stays high until the operation is complete. Every operation runs a search wave through the
// chain of MAX_SEGMENTS table cells, one cell per cycle. Allocate first rounds the request, one
// remainder bit a cycle, and registers the rounded sizes; after the wave it adds an insert when
// the fit is not exact, the write and the second fill output. Free adds the write and the merges
// with free neighbours above and below; translate and size query add none. Results appear on
// rsp_data for one cycle each, flagged by rsp_valid, and must be taken then: the receiver cannot
// stall. A successful allocate gives two results, the rest one. Register writes are taken only
// while idle and no start is pending. After reset and after a memory_size write the table is
// initialised in state S_INIT.
// depends on fba_pkg, fba_rounder, fba_cell and assert_macros.svh
`include "assert_macros.svh"

module best_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = fba_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = fba_pkg::ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  fba_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output fba_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [fba_pkg::GRAN_W-1:0] csr_wdata
);
   import fba_pkg::*;

   localparam int IW    = $clog2(MAX_SEGMENTS);
   localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
   localparam int LEN_W = ADDR_BITS + 1;
   localparam int CW    = (LEN_W > 18) ? LEN_W : 18;
   localparam int SW    = CW + 1;

   state_type state_ff, state_in;

   logic [GRAN_W-1:0] unit_ff, page_ff;
   logic [LEN_W-1:0]  memsz_ff;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [IW-1:0]     scan_ff, scan_in;
   req_type           req_ff;
   logic [SIZE_W-1:0] size_ff, used_ff;

   logic              best_found_ff;
   logic [IW-1:0]     best_idx_ff;
   logic [ADDR_BITS-1:0] best_start_ff;
   logic [LEN_W-1:0]  best_len_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic accept, csr_write;
   logic [GRAN_W-1:0] page_eff;
   logic rnd_done;
   logic [SIZE_W-1:0] rnd_size, rnd_used;

   cell_ctl_type      ctl;
   logic [IW-1:0]     pos;
   logic [7:0]        wr_owner;
   logic [ADDR_BITS-1:0] wr_start;
   logic [LEN_W-1:0]  wr_length, wr_used;

   logic [7:0]           owner_a  [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] start_a  [MAX_SEGMENTS];
   logic [LEN_W-1:0]     length_a [MAX_SEGMENTS];
   logic [LEN_W-1:0]     used_a   [MAX_SEGMENTS];
   logic                 cf_a     [MAX_SEGMENTS];
   logic [IW-1:0]        ci_a     [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] cs_a     [MAX_SEGMENTS];
   logic [LEN_W-1:0]     cl_a     [MAX_SEGMENTS];
   logic [MAX_SEGMENTS-1:0] free_vec;

   logic              cand_found;
   logic [IW-1:0]     cand_idx;
   logic [ADDR_BITS-1:0] cand_start;
   logic [LEN_W-1:0]  cand_len;
   logic              fits_exact;

   logic [IW:0]       nxt_idx;
   logic              hi_free, lo_free;
   logic [SW-1:0]     split_start, fill2_start, tr_sum;
   logic [CW-1:0]     split_len;
   logic [7:0]        id8;

   assign busy      = state_ff != S_IDLE;
   assign accept    = start && !busy;
   // a pending start goes first, so a register never changes under an accepted transaction
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign csr_write = csr_valid && csr_ready;
   assign page_eff  = (page_ff > unit_ff) ? page_ff : unit_ff;
   assign id8       = {1'b0, req_ff.owner_id};

   // granule and memory size clamping
   function automatic logic [GRAN_W-1:0] clamp_gran(input logic [GRAN_W-1:0] v);
      logic [GRAN_W-1:0] r;
      r = v;
      if (v == '0) r = GRAN_W'(1);
      else if (v > GRAN_MAX) r = GRAN_MAX;
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] clamp_mem(input logic [GRAN_W-1:0] v);
      logic [SW-1:0] e;
      logic [SW-1:0] lim;
      e   = SW'(v);
      lim = SW'(1) << ADDR_BITS;
      if (e == '0) e = SW'(1);
      else if (e > lim) e = lim;
      return e[LEN_W-1:0];
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff  <= GRAN_RESET;
         page_ff  <= GRAN_RESET;
         memsz_ff <= clamp_mem(GRAN_MAX);
      end else if (csr_write) begin
         case (csr_index)
            CSR_ALLOC_UNIT:  unit_ff  <= clamp_gran(csr_wdata);
            CSR_PAGE_SIZE:   page_ff  <= clamp_gran(csr_wdata);
            CSR_MEMORY_SIZE: memsz_ff <= clamp_mem(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   fba_rounder u_rounder (
      .clock         (clock),
      .reset         (reset),
      .start         (accept && (req_data.func == FUNC_ALLOC)),
      .request_bytes (req_data.request_bytes),
      .unit          (unit_ff),
      .page          (page_eff),
      .done          (rnd_done),
      .size          (rnd_size),
      .used          (rnd_used)
   );

   // chain of table cells
   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      if (k == 0) begin : g_first
         fba_cell #(.ADDR_BITS(ADDR_BITS), .MAX_SEGMENTS(MAX_SEGMENTS), .IDX(k)) u_cell (
            .clock (clock), .reset (reset), .ctl (ctl), .pos (pos), .count (count_ff),
            .key_owner (id8), .size (CW'(size_ff)),
            .wr_owner (wr_owner), .wr_start (wr_start), .wr_length (wr_length),
            .wr_used (wr_used),
            .prev_owner (owner_a[k]), .prev_start (start_a[k]),
            .prev_length (length_a[k]), .prev_used (used_a[k]),
            .next_owner (owner_a[(k+1)%MAX_SEGMENTS]),
            .next_start (start_a[(k+1)%MAX_SEGMENTS]),
            .next_length (length_a[(k+1)%MAX_SEGMENTS]),
            .next_used (used_a[(k+1)%MAX_SEGMENTS]),
            .owner (owner_a[k]), .start (start_a[k]), .length (length_a[k]),
            .used (used_a[k]),
            .cin_found (1'b0), .cin_idx ('0), .cin_start ('0), .cin_length ('0),
            .cout_found (cf_a[k]), .cout_idx (ci_a[k]), .cout_start (cs_a[k]),
            .cout_length (cl_a[k])
         );
      end else if (k == MAX_SEGMENTS - 1) begin : g_last
         fba_cell #(.ADDR_BITS(ADDR_BITS), .MAX_SEGMENTS(MAX_SEGMENTS), .IDX(k)) u_cell (
            .clock (clock), .reset (reset), .ctl (ctl), .pos (pos), .count (count_ff),
            .key_owner (id8), .size (CW'(size_ff)),
            .wr_owner (wr_owner), .wr_start (wr_start), .wr_length (wr_length),
            .wr_used (wr_used),
            .prev_owner (owner_a[k-1]), .prev_start (start_a[k-1]),
            .prev_length (length_a[k-1]), .prev_used (used_a[k-1]),
            .next_owner (owner_a[k]), .next_start (start_a[k]),
            .next_length (length_a[k]), .next_used (used_a[k]),
            .owner (owner_a[k]), .start (start_a[k]), .length (length_a[k]),
            .used (used_a[k]),
            .cin_found (cf_a[k-1]), .cin_idx (ci_a[k-1]), .cin_start (cs_a[k-1]),
            .cin_length (cl_a[k-1]),
            .cout_found (cf_a[k]), .cout_idx (ci_a[k]), .cout_start (cs_a[k]),
            .cout_length (cl_a[k])
         );
      end else begin : g_mid
         fba_cell #(.ADDR_BITS(ADDR_BITS), .MAX_SEGMENTS(MAX_SEGMENTS), .IDX(k)) u_cell (
            .clock (clock), .reset (reset), .ctl (ctl), .pos (pos), .count (count_ff),
            .key_owner (id8), .size (CW'(size_ff)),
            .wr_owner (wr_owner), .wr_start (wr_start), .wr_length (wr_length),
            .wr_used (wr_used),
            .prev_owner (owner_a[k-1]), .prev_start (start_a[k-1]),
            .prev_length (length_a[k-1]), .prev_used (used_a[k-1]),
            .next_owner (owner_a[k+1]), .next_start (start_a[k+1]),
            .next_length (length_a[k+1]), .next_used (used_a[k+1]),
            .owner (owner_a[k]), .start (start_a[k]), .length (length_a[k]),
            .used (used_a[k]),
            .cin_found (cf_a[k-1]), .cin_idx (ci_a[k-1]), .cin_start (cs_a[k-1]),
            .cin_length (cl_a[k-1]),
            .cout_found (cf_a[k]), .cout_idx (ci_a[k]), .cout_start (cs_a[k]),
            .cout_length (cl_a[k])
         );
      end
      assign free_vec[k] = owner_a[k] == FREE_OWNER;
   end

   // end of the search wave
   assign cand_found = cf_a[MAX_SEGMENTS-1];
   assign cand_idx   = ci_a[MAX_SEGMENTS-1];
   assign cand_start = cs_a[MAX_SEGMENTS-1];
   assign cand_len   = cl_a[MAX_SEGMENTS-1];
   assign fits_exact = CW'(cand_len) == CW'(size_ff);

   // neighbour checks for the merge after a free
   assign nxt_idx = (IW+1)'(best_idx_ff) + (IW+1)'(1);
   assign hi_free = ((CNTW+1)'(nxt_idx) < (CNTW+1)'(count_ff)) ?
                    free_vec[nxt_idx[IW-1:0]] : 1'b0;
   assign lo_free = (best_idx_ff != '0) ? free_vec[best_idx_ff - IW'(1)] : 1'b0;

   // address arithmetic
   assign split_start = SW'(best_start_ff) + SW'(size_ff);
   assign split_len   = CW'(best_len_ff) - CW'(size_ff);
   assign fill2_start = SW'(best_start_ff) + SW'(used_ff);
   assign tr_sum      = SW'(cand_start) + SW'(req_ff.offset);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               state_in = (req_data.func == FUNC_ALLOC) ? S_ROUND : S_SCAN;
            end else if (csr_write && (csr_index == CSR_MEMORY_SIZE)) begin
               state_in = S_INIT;
            end
         end
         S_ROUND: if (rnd_done) state_in = S_SCAN;
         S_SCAN: if (scan_ff == IW'(MAX_SEGMENTS - 1)) state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_IDLE;
            if (cand_found) begin
               if (req_ff.func == FUNC_ALLOC) begin
                  if (fits_exact) state_in = S_WRITE;
                  else if (count_ff != CNTW'(MAX_SEGMENTS)) state_in = S_INSERT;
               end else if (req_ff.func == FUNC_FREE) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_INSERT: state_in = S_WRITE;
         S_WRITE: state_in = (req_ff.func == FUNC_ALLOC) ? S_FILL2 : S_MERGE_HI;
         S_FILL2: state_in = S_IDLE;
         S_MERGE_HI: state_in = S_MERGE_LO;
         S_MERGE_LO: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: cell commands, table count and results
   always_comb begin
      ctl.op         = OP_HOLD;
      ctl.scan_alloc = req_ff.func == FUNC_ALLOC;
      pos            = best_idx_ff;
      wr_owner       = FREE_OWNER;
      wr_start       = best_start_ff;
      wr_length      = best_len_ff;
      wr_used        = '0;
      count_in       = count_ff;
      scan_in        = '0;
      rsp_valid_in   = 1'b0;
      rsp_in         = '0;
      rsp_in.last    = 1'b1;
      unique case (state_ff)
         S_INIT: begin
            ctl.op    = OP_WRITE;
            pos       = '0;
            wr_start  = '0;
            wr_length = memsz_ff;
            count_in  = CNTW'(1);
         end
         S_SCAN: scan_in = scan_ff + IW'(1);
         S_DECIDE: begin
            if (!cand_found) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = (req_ff.func == FUNC_ALLOC) ? STATUS_NO_FIT : STATUS_NOT_FOUND;
            end else if (req_ff.func == FUNC_ALLOC) begin
               if (!fits_exact && (count_ff == CNTW'(MAX_SEGMENTS))) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_FULL;
               end
            end else if (req_ff.func == FUNC_TRANSLATE) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.value  = tr_sum[16:0];
            end else if (req_ff.func == FUNC_SIZE) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.value  = 17'(CW'(cand_len));
            end
         end
         S_INSERT: begin
            ctl.op    = OP_INSERT;
            pos       = nxt_idx[IW-1:0];
            wr_start  = split_start[ADDR_BITS-1:0];
            wr_length = split_len[LEN_W-1:0];
            count_in  = count_ff + CNTW'(1);
         end
         S_WRITE: begin
            ctl.op            = OP_WRITE;
            rsp_valid_in      = 1'b1;
            rsp_in.status     = STATUS_OK;
            rsp_in.fill_valid = 1'b1;
            rsp_in.fill_start = 16'(SW'(best_start_ff));
            if (req_ff.func == FUNC_ALLOC) begin
               wr_owner           = id8;
               wr_length          = LEN_W'(CW'(size_ff));
               wr_used            = LEN_W'(CW'(used_ff));
               rsp_in.fill_length = used_ff[16:0];
               rsp_in.fill_value  = id8;
               rsp_in.last        = 1'b0;
            end else begin
               rsp_in.fill_length = 17'(CW'(best_len_ff));
               rsp_in.fill_value  = FREE_OWNER;
            end
         end
         S_FILL2: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STATUS_OK;
            rsp_in.fill_valid  = 1'b1;
            rsp_in.fill_start  = 16'(SW'(fill2_start[ADDR_BITS-1:0]));
            rsp_in.fill_length = 17'(size_ff - used_ff);
            rsp_in.fill_value  = FREE_OWNER;
         end
         S_MERGE_HI: begin
            if (hi_free) begin
               ctl.op   = OP_MERGE;
               count_in = count_ff - CNTW'(1);
            end
         end
         S_MERGE_LO: begin
            if (lo_free) begin
               ctl.op   = OP_MERGE;
               pos      = best_idx_ff - IW'(1);
               count_in = count_ff - CNTW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= CNTW'(1);
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (accept) req_ff <= req_data;
      if (state_ff == S_ROUND && rnd_done) begin
         size_ff <= rnd_size;
         used_ff <= rnd_used;
      end
      if (state_ff == S_DECIDE) begin
         best_found_ff <= cand_found;
         best_idx_ff   <= cand_idx;
         best_start_ff <= cand_start;
         best_len_ff   <= cand_len;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // transaction checks
   `ASSERT_NEVER(a_count_range, clock, reset,
      (count_ff == '0) || (count_ff > CNTW'(MAX_SEGMENTS)), "segment count out of range")
   `ASSERT_NEXT(a_first_fill_pair, clock, reset,
      rsp_valid_ff && !rsp_ff.last, rsp_valid_ff && rsp_ff.last, "allocate lost second fill")
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy not raised after start")
   `ASSERT_NEVER(a_update_found, clock, reset,
      ((state_ff == S_WRITE) || (state_ff == S_INSERT)) && !best_found_ff,
      "table update without a selected segment")

endmodule
